FILE: rtl/cidr_whitelist_packet_classifier_macros.svh
// Assertion macros for the prefix whitelist classifier.
// Included by the top level; no other dependencies.
`ifndef CIDR_WHITELIST_PACKET_CLASSIFIER_MACROS_SVH
`define CIDR_WHITELIST_PACKET_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define CWPC_ASSERT_CLK(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("cwpc assertion failed");
// Expression must never be true outside reset.
`define CWPC_ASSERT_NEVER(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) \
    else $error("cwpc forbidden condition seen");
`else
`define CWPC_ASSERT_CLK(lbl, clk_s, rst_s, prop)
`define CWPC_ASSERT_NEVER(lbl, clk_s, rst_s, expr)
`endif

`endif

FILE: rtl/cwpc_pkg.sv
// Shared types, constants and helpers for the prefix whitelist classifier.
// No dependencies; imported by the top level, cwpc_cell and the testbench.
`timescale 1ns / 1ps
package cwpc_pkg;

  // Table geometry: entries are spread over a row of cells
  localparam int unsigned TABLE_ENTRIES_DEFAULT = 1024;
  localparam int unsigned CELLS                 = 16;
  localparam int unsigned CELL_W                = $clog2(CELLS);

  // Configuration port
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DNS_PORT   = 1'd0,
    REG_PROXY_MARK = 1'd1
  } cfg_reg_t;

  localparam logic [15:0] DNS_PORT_RESET   = 16'd53;
  localparam logic [31:0] PROXY_MARK_RESET = 32'd1;

  // Header checks
  localparam logic [15:0] ETH_HDR_BYTES   = 16'd14;
  localparam logic [15:0] IPV4_END_BYTES  = 16'd34;
  localparam logic [15:0] UDP_END_BYTES   = 16'd42;
  localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;
  localparam logic [5:0]  MAX_PREFIX_BITS = 6'd32;

  typedef enum logic [2:0] {
    VERDICT_PASS      = 3'd0,
    VERDICT_WHITELIST = 3'd1,
    VERDICT_DNS       = 3'd2,
    VERDICT_MARKED    = 3'd3,
    VERDICT_WRITE     = 3'd4
  } verdict_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] frame_len;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] dst_addr;
    logic [15:0] udp_dst_port;
    logic [9:0]  entry_index;
    logic [31:0] entry_prefix;
    logic [5:0]  entry_length;
    logic        entry_valid;
  } req_t;

  typedef struct packed {
    verdict_t    verdict;
    logic        mark_written;
    logic [31:0] mark_out;
    logic [31:0] bypass_total;
    logic [31:0] proxy_total;
  } rsp_t;

  // One whitelist slot as stored in a cell memory
  typedef struct packed {
    logic        valid;
    logic [5:0]  length;
    logic [31:0] prefix;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Network mask for a prefix length; lengths above 32 act as 32
  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] mask;
    if (len >= MAX_PREFIX_BITS) begin
      mask = '1;
    end else begin
      mask = ~(32'hFFFF_FFFF >> len);
    end
    return mask;
  endfunction

endpackage

FILE: rtl/cidr_whitelist_packet_classifier.sv
// Top level of the IPv4 prefix whitelist classifier: control, counters, cell row.
// Depends on cwpc_pkg, cwpc_cell, cwpc_ram and the assertion macro header.
//
//  Channel | Signals                       | Payload
//  --------+-------------------------------+-------------------------------
//  request | req_valid / req_ready         | req (req_t)
//  result  | rsp_valid / rsp_ready         | rsp (rsp_t)
//  config  | cfg_we, cfg_index             | cfg_data (32 bits)
//
// Slots are spread over 16 cells of ROWS = ceil(TABLE_ENTRIES / 16) rows each.
// A classify transaction's length is set by the row sweep of the cell memories:
// scan reads one row of every cell per cycle over all ROWS, then drain and result.
// A table write passes the write state; a frame that fails the header checks goes
// straight to result. After reset a clearing pass zeroes every slot; no request is
// taken meanwhile. A waiting result does not block the next request.
`timescale 1ns / 1ps
`include "cidr_whitelist_packet_classifier_macros.svh"
module cidr_whitelist_packet_classifier
  import cwpc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  req_t                   req,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output rsp_t                   rsp,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned ROWS  = (TABLE_ENTRIES + CELLS - 1) / CELLS;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  state_t            state, state_next;
  logic [ROW_W-1:0]  row, row_next;
  logic              rd_pend, rd_pend_next;
  logic              hit_acc, hit_acc_next;
  logic              rsp_load;
  rsp_t              rsp_next;
  logic [31:0]       bypass_cnt, proxy_cnt;
  logic [15:0]       dns_port;
  logic [31:0]       proxy_mark;
  req_t              item;

  logic [CELLS-1:0]  cell_we;
  logic [ROW_W-1:0]  cell_wrow;
  entry_t            cell_wentry;
  logic [CELLS:0]    hit_chain;

  logic              req_fire;
  logic              req_parsed;
  logic              item_parsed;
  logic              item_dns;
  logic [31:0]       idx32;
  logic              idx_in_range;
  logic [CELL_W-1:0] idx_cell;
  logic [ROW_W-1:0]  idx_row;

  assign req_fire = req_valid && req_ready;
  assign req_ready = (state == ST_IDLE);

  // Header checks on the incoming and the held transaction
  assign req_parsed  = (req.frame_len >= ETH_HDR_BYTES) &&
                       (req.ether_type == ETHERTYPE_IPV4) &&
                       (req.frame_len >= IPV4_END_BYTES);
  assign item_parsed = (item.frame_len >= ETH_HDR_BYTES) &&
                       (item.ether_type == ETHERTYPE_IPV4) &&
                       (item.frame_len >= IPV4_END_BYTES);
  assign item_dns    = (item.ip_protocol == PROTO_UDP) &&
                       (item.frame_len >= UDP_END_BYTES) &&
                       (item.udp_dst_port == dns_port);

  // Split a slot index into cell and row
  assign idx32        = 32'(item.entry_index);
  assign idx_in_range = idx32 < 32'(TABLE_ENTRIES);
  assign idx_cell     = idx32[CELL_W-1:0];
  assign idx_row      = idx32[CELL_W +: ROW_W];

  // Row of match cells
  assign hit_chain[0] = 1'b0;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    cwpc_cell #(
      .ROWS (ROWS)
    ) u_cell (
      .clk      (clk),
      .wr_en    (cell_we[k]),
      .wr_row   (cell_wrow),
      .wr_entry (cell_wentry),
      .rd_row   (row),
      .addr     (item.dst_addr),
      .hit_in   (hit_chain[k]),
      .hit_out  (hit_chain[k+1])
    );
  end

  // Sequencer: clearing pass, writes, row sweep, result hand-off
  always_comb begin
    state_next   = state;
    row_next     = row;
    rd_pend_next = 1'b0;
    hit_acc_next = hit_acc;
    cell_we      = '0;
    cell_wrow    = row;
    cell_wentry  = '0;
    rsp_load     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cell_we = '1;
        if (row == LAST_ROW) begin
          row_next   = '0;
          state_next = ST_IDLE;
        end else begin
          row_next = row + ROW_W'(1);
        end
      end
      ST_IDLE: begin
        hit_acc_next = 1'b0;
        row_next     = '0;
        if (req_fire) begin
          if (req.req_type) begin
            state_next = ST_WRITE;
          end else if (req_parsed) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_WRITE: begin
        cell_we[idx_cell]  = idx_in_range;
        cell_wrow          = idx_row;
        cell_wentry.valid  = item.entry_valid;
        cell_wentry.length = item.entry_length;
        cell_wentry.prefix = item.entry_prefix;
        state_next         = ST_RESP;
      end
      ST_SCAN: begin
        rd_pend_next = 1'b1;
        if (rd_pend) begin
          hit_acc_next = hit_acc | hit_chain[CELLS];
        end
        if (row == LAST_ROW) begin
          row_next   = '0;
          state_next = ST_DRAIN;
        end else begin
          row_next = row + ROW_W'(1);
        end
      end
      ST_DRAIN: begin
        if (rd_pend) begin
          hit_acc_next = hit_acc | hit_chain[CELLS];
        end
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Build the result and the counter values after it
  always_comb begin
    rsp_next.mark_written = 1'b0;
    rsp_next.mark_out     = 32'd0;
    rsp_next.bypass_total = bypass_cnt;
    rsp_next.proxy_total  = proxy_cnt;
    if (item.req_type) begin
      rsp_next.verdict = VERDICT_WRITE;
    end else if (!item_parsed) begin
      rsp_next.verdict = VERDICT_PASS;
    end else if (hit_acc) begin
      rsp_next.verdict      = VERDICT_WHITELIST;
      rsp_next.bypass_total = bypass_cnt + 32'd1;
    end else if (item_dns) begin
      rsp_next.verdict      = VERDICT_DNS;
      rsp_next.bypass_total = bypass_cnt + 32'd1;
    end else begin
      rsp_next.verdict      = VERDICT_MARKED;
      rsp_next.mark_written = 1'b1;
      rsp_next.mark_out     = proxy_mark;
      rsp_next.proxy_total  = proxy_cnt + 32'd1;
    end
  end

  // Control state, counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      row        <= '0;
      rd_pend    <= 1'b0;
      hit_acc    <= 1'b0;
      rsp_valid  <= 1'b0;
      bypass_cnt <= 32'd0;
      proxy_cnt  <= 32'd0;
      dns_port   <= DNS_PORT_RESET;
      proxy_mark <= PROXY_MARK_RESET;
    end else begin
      state   <= state_next;
      row     <= row_next;
      rd_pend <= rd_pend_next;
      hit_acc <= hit_acc_next;
      if (rsp_load) begin
        rsp_valid  <= 1'b1;
        bypass_cnt <= rsp_next.bypass_total;
        proxy_cnt  <= rsp_next.proxy_total;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_DNS_PORT:   dns_port   <= cfg_data[15:0];
          REG_PROXY_MARK: proxy_mark <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end

  // Hold the accepted transaction and the outgoing result
  always_ff @(posedge clk) begin
    if (req_fire) begin
      item <= req;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // Counters move only when a result is loaded
  `CWPC_ASSERT_CLK(a_cnt_hold, clk, rst, !rsp_load |=> $stable(bypass_cnt) && $stable(proxy_cnt))
  // Table writes leave both counters untouched
  `CWPC_ASSERT_CLK(a_write_no_count, clk, rst, (rsp_load && item.req_type) |=> ($stable(bypass_cnt) && $stable(proxy_cnt)))
  // A mark is reported exactly for marked packets
  `CWPC_ASSERT_NEVER(a_mark_verdict, clk, rst, rsp_valid && (rsp.mark_written != (rsp.verdict == VERDICT_MARKED)))

endmodule

FILE: rtl/cwpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cwpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cwpc_cell.sv
// One cell of the match chain: a bank of whitelist rows and a prefix compare.
// Depends on cwpc_pkg and cwpc_ram.
`timescale 1ns / 1ps
module cwpc_cell
  import cwpc_pkg::*;
#(
  parameter int unsigned ROWS = 64
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] wr_row,
  input  entry_t                                  wr_entry,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_row,
  input  logic [31:0]                             addr,
  input  logic                                    hit_in,
  output logic                                    hit_out
);

  logic [ENTRY_W-1:0] rd_data;
  entry_t             rd_entry;
  logic               match;

  cwpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ROWS)
  ) u_bank (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_row),
    .wdata (wr_entry),
    .raddr (rd_row),
    .rdata (rd_data)
  );

  // Compare the row read last cycle against the held destination
  assign rd_entry = entry_t'(rd_data);
  assign match    = rd_entry.valid &&
                    (((addr ^ rd_entry.prefix) & prefix_mask(rd_entry.length)) == 32'd0);

  // Pass the hit on to the next cell
  assign hit_out = hit_in | match;

endmodule

FILE: tb/cidr_whitelist_packet_classifier_tb.sv
// Self-checking testbench for the IPv4 prefix whitelist classifier.
// Depends on cwpc_pkg and the cidr_whitelist_packet_classifier RTL; predicts
// every verdict and counter value and compares each result transaction.
`timescale 1ns / 1ps
module cidr_whitelist_packet_classifier_tb;
  import cwpc_pkg::*;

  localparam int unsigned SLOTS = TABLE_ENTRIES_DEFAULT;
  localparam int unsigned MAX_ERR_LINES = 50;

  logic                   clk;
  logic                   rst;
  logic                   req_valid;
  logic                   req_ready;
  req_t                   req;
  logic                   rsp_valid;
  logic                   rsp_ready;
  rsp_t                   rsp;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  cidr_whitelist_packet_classifier uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted table, counters and register copies
  bit          slot_live [SLOTS];
  logic [31:0] slot_net  [SLOTS];
  logic [5:0]  slot_len  [SLOTS];
  logic [31:0] bypass_seen;
  logic [31:0] proxy_seen;
  logic [15:0] cfg_dns;
  logic [31:0] cfg_mark;

  // Generator view of installed prefixes, used to aim addresses at the table
  typedef struct {
    logic [9:0]  idx;
    logic [31:0] net;
    logic [5:0]  len;
  } listed_t;
  listed_t listed [$];

  req_t        request_queue [$];
  rsp_t        pending_verdicts [$];
  int          in_flight;
  int unsigned error_count;
  bit          req_took;
  bit          rsp_took;
  bit          send_burst;
  bit          recv_burst;
  int unsigned send_gap;
  int unsigned recv_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL cidr_whitelist_packet_classifier");
    $finish;
  end

  task automatic flag_error(string msg);
    if (error_count < MAX_ERR_LINES) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // True when any live slot matches addr on its leading bits
  function automatic bit prefix_listed(logic [31:0] addr);
    int unsigned keep;
    logic [63:0] diff;
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_live[s]) begin
        keep = (slot_len[s] > 6'd32) ? 32 : int'(slot_len[s]);
        diff = {32'd0, addr ^ slot_net[s]};
        if ((diff >> (32 - keep)) == 64'd0) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one transaction to the predicted state and return its result
  function automatic rsp_t classify_item(req_t r);
    rsp_t o;
    o = '0;
    o.verdict = VERDICT_PASS;
    if (r.req_type) begin
      if (r.entry_index < SLOTS) begin
        slot_live[r.entry_index] = r.entry_valid;
        slot_net[r.entry_index]  = r.entry_prefix;
        slot_len[r.entry_index]  = r.entry_length;
      end
      o.verdict = VERDICT_WRITE;
    end else if (r.frame_len < ETH_HDR_BYTES || r.ether_type != ETHERTYPE_IPV4 ||
                 r.frame_len < IPV4_END_BYTES) begin
      o.verdict = VERDICT_PASS;
    end else if (prefix_listed(r.dst_addr)) begin
      bypass_seen = bypass_seen + 32'd1;
      o.verdict = VERDICT_WHITELIST;
    end else if (r.ip_protocol == PROTO_UDP && r.frame_len >= UDP_END_BYTES &&
                 r.udp_dst_port == cfg_dns) begin
      bypass_seen = bypass_seen + 32'd1;
      o.verdict = VERDICT_DNS;
    end else begin
      proxy_seen = proxy_seen + 32'd1;
      o.mark_written = 1'b1;
      o.mark_out = cfg_mark;
      o.verdict = VERDICT_MARKED;
    end
    o.bypass_total = bypass_seen;
    o.proxy_total = proxy_seen;
    return o;
  endfunction

  task automatic queue_item(req_t r);
    request_queue.push_back(r);
    in_flight++;
  endtask

  // Classify transaction; the table fields carry random don't-care bits
  function automatic req_t packet(logic [15:0] flen, logic [15:0] etype,
                                  logic [7:0] proto, logic [31:0] addr,
                                  logic [15:0] port);
    req_t r;
    r.req_type     = 1'b0;
    r.frame_len    = flen;
    r.ether_type   = etype;
    r.ip_protocol  = proto;
    r.dst_addr     = addr;
    r.udp_dst_port = port;
    r.entry_index  = 10'($urandom);
    r.entry_prefix = $urandom;
    r.entry_length = 6'($urandom);
    r.entry_valid  = 1'($urandom);
    return r;
  endfunction

  // Table write transaction; the header fields carry random don't-care bits
  function automatic req_t table_write(logic [9:0] idx, logic [31:0] net,
                                       logic [5:0] len, logic vld);
    req_t r;
    r = packet(16'($urandom), 16'($urandom), 8'($urandom), $urandom, 16'($urandom));
    r.req_type     = 1'b1;
    r.entry_index  = idx;
    r.entry_prefix = net;
    r.entry_length = len;
    r.entry_valid  = vld;
    return r;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_DNS_PORT) cfg_dns = value[15:0];
    else cfg_mark = value;
  endtask

  // Hold until every queued transaction is accepted and answered
  task automatic wait_drained();
    while (in_flight != 0 || pending_verdicts.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed IPv4 traffic aimed at the table, plus writes and noise
  task automatic queue_random_items(int unsigned count);
    req_t        r;
    listed_t     e;
    int unsigned pick;
    int unsigned keep;
    for (int unsigned n = 0; n < count; n++) begin
      r = packet(16'($urandom), 16'($urandom), 8'($urandom), $urandom, 16'($urandom));
      if ($urandom_range(0, 4) == 0) begin
        r.req_type = 1'b1;
        if (listed.size() > 0 && $urandom_range(0, 2) == 0) begin
          pick = $urandom_range(0, listed.size() - 1);
          r.entry_index = listed[pick].idx;
          r.entry_valid = 1'b0;
          listed.delete(pick);
        end else begin
          r.entry_valid = 1'b1;
          if ($urandom_range(0, 4) == 0) r.entry_length = 6'($urandom_range(33, 63));
          else r.entry_length = 6'($urandom_range(8, 32));
          e.idx = r.entry_index;
          e.net = r.entry_prefix;
          e.len = r.entry_length;
          listed.push_back(e);
        end
      end else begin
        r.req_type = 1'b0;
        if ($urandom_range(0, 3) != 0) begin
          r.ether_type = ETHERTYPE_IPV4;
          if ($urandom_range(0, 7) == 0) r.frame_len = 16'($urandom_range(34, 45));
          else r.frame_len = 16'($urandom_range(34, 1518));
        end else begin
          if ($urandom_range(0, 1) == 0) r.ether_type = ETHERTYPE_IPV4;
          if ($urandom_range(0, 1) == 0) r.frame_len = 16'($urandom_range(0, 40));
        end
        if (listed.size() > 0 && $urandom_range(0, 1) == 0) begin
          e = listed[$urandom_range(0, listed.size() - 1)];
          keep = (e.len > 6'd32) ? 32 : int'(e.len);
          r.dst_addr = e.net ^ ($urandom >> keep);
        end
        if ($urandom_range(0, 1) == 0) r.ip_protocol = PROTO_UDP;
        if ($urandom_range(0, 1) == 0) r.udp_dst_port = cfg_dns;
      end
      queue_item(r);
    end
  endtask

  // Drive request transactions from the queue, with random gaps between them
  always @(negedge clk) begin : drive_requests
    logic next_valid;
    req_t next_req;
    next_valid = req_valid;
    next_req   = req;
    if (req_took) next_valid = 1'b0;
    if (!rst && !next_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (request_queue.size() > 0) begin
        next_req   = request_queue.pop_front();
        next_valid = 1'b1;
        if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 13);
      end
    end
    req_valid <= next_valid;
    req       <= next_req;
  end

  // Stall the result channel for a random gap after each accepted result
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_took) begin
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 13);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Predict on accepted requests, check accepted results
  always @(posedge clk) begin : watch_channels
    rsp_t want;
    req_took = 1'b0;
    rsp_took = 1'b0;
    if (!rst) begin
      if (req_valid && req_ready) begin
        req_took = 1'b1;
        pending_verdicts.push_back(classify_item(req));
        in_flight--;
      end
      if (rsp_valid && rsp_ready) begin
        rsp_took = 1'b1;
        if (pending_verdicts.size() == 0) begin
          flag_error("result transaction with nothing expected");
        end else begin
          want = pending_verdicts.pop_front();
          if (rsp.verdict !== want.verdict)
            flag_error($sformatf("verdict got %0d want %0d", rsp.verdict, want.verdict));
          if (rsp.mark_written !== want.mark_written)
            flag_error($sformatf("mark_written got %0b want %0b",
                                 rsp.mark_written, want.mark_written));
          if (rsp.mark_out !== want.mark_out)
            flag_error($sformatf("mark_out got %h want %h", rsp.mark_out, want.mark_out));
          if (rsp.bypass_total !== want.bypass_total)
            flag_error($sformatf("bypass_total got %0d want %0d",
                                 rsp.bypass_total, want.bypass_total));
          if (rsp.proxy_total !== want.proxy_total)
            flag_error($sformatf("proxy_total got %0d want %0d",
                                 rsp.proxy_total, want.proxy_total));
        end
      end
    end
  end

  initial begin
    logic [15:0] dns_plan  [5];
    logic [31:0] mark_plan [5];
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    rsp_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_DNS_PORT;
    cfg_data    = '0;
    in_flight   = 0;
    error_count = 0;
    req_took    = 1'b0;
    rsp_took    = 1'b0;
    send_burst  = 1'b0;
    recv_burst  = 1'b0;
    send_gap    = 0;
    recv_gap    = 0;
    bypass_seen = '0;
    proxy_seen  = '0;
    cfg_dns     = DNS_PORT_RESET;
    cfg_mark    = PROXY_MARK_RESET;
    for (int s = 0; s < SLOTS; s++) begin
      slot_live[s] = 1'b0;
      slot_net[s]  = '0;
      slot_len[s]  = '0;
    end
    dns_plan  = '{16'd0, 16'hFFFF, 16'($urandom), DNS_PORT_RESET, 16'd5353};
    mark_plan = '{32'hFFFF_FFFF, 32'd0, $urandom, PROXY_MARK_RESET, 32'h8000_0001};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Header checks and table behavior under the reset register values
    queue_item(packet(16'd0,  ETHERTYPE_IPV4, PROTO_UDP, 32'h0A00_0001, 16'd53));
    queue_item(packet(16'd13, ETHERTYPE_IPV4, PROTO_UDP, 32'h0A00_0001, 16'd53));
    queue_item(packet(16'd14, 16'h86DD,       PROTO_UDP, 32'h0A00_0001, 16'd53));
    queue_item(packet(16'd33, ETHERTYPE_IPV4, PROTO_UDP, 32'h0A00_0001, 16'd53));
    queue_item(packet(16'd34, ETHERTYPE_IPV4, 8'd6,      32'h0A00_0001, 16'd53));
    // UDP to the DNS port one byte short of a full UDP header gets marked
    queue_item(packet(16'd41, ETHERTYPE_IPV4, PROTO_UDP, 32'h0A00_0001, 16'd53));
    queue_item(packet(16'd42, ETHERTYPE_IPV4, PROTO_UDP, 32'h0A00_0001, 16'd53));
    queue_item(packet(16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
    queue_item(packet(16'hFFFF, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 16'd52));
    queue_item(table_write(10'd0, 32'h0A00_0000, 6'd8, 1'b1));
    queue_item(packet(16'd60, ETHERTYPE_IPV4, 8'd6, 32'h0AFF_0102, 16'd0));
    queue_item(packet(16'd60, ETHERTYPE_IPV4, PROTO_UDP, 32'h0B00_0000, 16'd53));
    // Length above 32 acts as a full host match
    queue_item(table_write(10'd1023, 32'hC0A8_0101, 6'd40, 1'b1));
    queue_item(packet(16'd1500, ETHERTYPE_IPV4, 8'd1, 32'hC0A8_0101, 16'd0));
    queue_item(packet(16'd1500, ETHERTYPE_IPV4, 8'd1, 32'hC0A8_0100, 16'd0));
    // Zero length matches every address until the slot is removed
    queue_item(table_write(10'd512, 32'hFFFF_FFFF, 6'd0, 1'b1));
    queue_item(packet(16'd64, ETHERTYPE_IPV4, 8'hFF, 32'h0, 16'hFFFF));
    queue_item(table_write(10'd512, 32'h0, 6'd63, 1'b0));
    queue_item(packet(16'd64, ETHERTYPE_IPV4, 8'hFF, 32'h0, 16'hFFFF));
    queue_item(table_write(10'd0, 32'h0A00_0000, 6'd8, 1'b0));
    queue_item(packet(16'd64, ETHERTYPE_IPV4, PROTO_UDP, 32'h0A01_0101, 16'd54));
    queue_item(table_write(10'd5, 32'h8000_0000, 6'd1, 1'b1));
    queue_item(packet(16'd64, ETHERTYPE_IPV4, 8'd6, 32'hFFFF_FFFF, 16'd0));
    queue_item(table_write(10'd5, 32'h8000_0000, 6'd1, 1'b0));
    wait_drained();

    // Random traffic under a series of register settings
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_DNS_PORT, {16'd0, dns_plan[p]});
      write_reg(REG_PROXY_MARK, mark_plan[p]);
      @(negedge clk);
      cfg_we <= 1'b0;
      queue_random_items(100);
      wait_drained();
    end

    // Let any stray result show up before the verdict
    repeat (80) @(posedge clk);
    if (pending_verdicts.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_verdicts.size()));
    if (error_count == 0) begin
      $display("PASS cidr_whitelist_packet_classifier");
    end else begin
      $display("FAIL cidr_whitelist_packet_classifier");
    end
    $finish;
  end

endmodule

FILE: cidr_whitelist_packet_classifier.f
+incdir+rtl
rtl/cwpc_pkg.sv
rtl/cwpc_ram.sv
rtl/cwpc_cell.sv
rtl/cidr_whitelist_packet_classifier.sv
tb/cidr_whitelist_packet_classifier_tb.sv
